### rtl/qdc_pkg.sv
// ----------------------------------------------------------------------------
// qdc_pkg
// Types and constants shared by the readout-word stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package qdc_pkg;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_EOB    = 2'd2
  } phase_t;

  // Command passed from the front end to the back end
  typedef enum logic [2:0] {
    OP_HDR  = 3'd0,
    OP_DATA = 3'd1,
    OP_EOB  = 3'd2,
    OP_ERR  = 3'd3,
    OP_QRY  = 3'd4
  } op_t;

  // Result kinds as seen on the output
  typedef enum logic [2:0] {
    K_HDR  = 3'd0,
    K_DATA = 3'd1,
    K_EOB  = 3'd2,
    K_SEL  = 3'd3,
    K_ERR  = 3'd4,
    K_QRY  = 3'd5
  } kind_t;

  // Back end sequencer
  typedef enum logic [2:0] {
    B_CLR  = 3'd0,
    B_IDLE = 3'd1,
    B_RD   = 3'd2,
    B_MEM  = 3'd3,
    B_EMIT = 3'd4,
    B_SCAN = 3'd5,
    B_SEL  = 3'd6
  } bst_t;

  // Register indexes
  localparam logic [2:0] REG_TYPE_MASK  = 3'd0;
  localparam logic [2:0] REG_HEADER_TAG = 3'd1;
  localparam logic [2:0] REG_DATA_TAG   = 3'd2;
  localparam logic [2:0] REG_END_TAG    = 3'd3;
  localparam logic [2:0] REG_FILLER_TAG = 3'd4;
  localparam logic [2:0] REG_SIXTEEN    = 3'd5;
  localparam logic [2:0] REG_SEL_MASK   = 3'd6;

  localparam logic [15:0] VALUE_ABSENT = 16'hFFFF;

  typedef struct packed {
    logic [31:0] type_mask;
    logic [31:0] header_tag;
    logic [31:0] data_tag;
    logic [31:0] end_tag;
    logic [31:0] filler_tag;
    logic        sixteen;
    logic [31:0] sel_mask;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  ch;
    logic [11:0] val;
    logic [23:0] evn;
    logic [31:0] events;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  channel;
    logic [15:0] value;
    logic [23:0] event_number;
    logic [31:0] events_seen;
    logic [31:0] bin_count;
    logic [31:0] hit_count;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

### rtl/qdc_event_stream_parser.sv
// ----------------------------------------------------------------------------
// qdc_event_stream_parser
// Readout-word parser with per-channel histograms and end-of-event readout.
// ----------------------------------------------------------------------------
//  channel   ports                           beat taken when
//  input     push/full, in_*                 push & ~full
//  result    empty/pop, out_*                pop & ~empty
//  config    psel/penable/pwrite/paddr/...   psel & penable & pwrite
//
// The front end takes one word a cycle while its 4-entry command queue has
// room. In the back end a header, error or event end is taken and emitted;
// a data word or histogram read is taken, read, then emitted, a data word
// with a read-modify-write of the histogram RAM. An event end then scans
// channels 0 to the highest selected one and emits each selected channel.
// After reset the histogram RAM, CHANNELS*BINS entries (131072 by default),
// is cleared one entry a cycle; full stays high meanwhile.
// A full result queue stalls the back end only, until the command queue fills.
`default_nettype none

module qdc_event_stream_parser #(
  parameter int CHANNELS = 32,
  parameter int BINS     = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_mode,
  input  logic [31:0] in_word,
  input  logic [4:0]  in_query_channel,
  input  logic [11:0] in_query_bin,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_kind,
  output logic [4:0]  out_channel,
  output logic [15:0] out_value,
  output logic [23:0] out_event_number,
  output logic [31:0] out_events_seen,
  output logic [31:0] out_bin_count,
  output logic [31:0] out_channel_hit_count,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import qdc_pkg::*;

  logic [31:0] type_mask_r, header_tag_r, data_tag_r, end_tag_r, filler_tag_r;
  logic        sixteen_r;
  logic [31:0] sel_mask_r;
  logic        cfg_we;
  cfg_t        cfg;

  logic        clr_busy;
  logic        cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t        cmd_in, cmd_dout;
  logic        res_push, res_full;
  res_t        res_in, res_dout;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_mask_r  <= 32'h0700_0000;
      header_tag_r <= 32'h0200_0000;
      data_tag_r   <= 32'h0000_0000;
      end_tag_r    <= 32'h0400_0000;
      filler_tag_r <= 32'h0600_0000;
      sixteen_r    <= 1'b0;
      sel_mask_r   <= 32'h0000_0000;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_TYPE_MASK:  type_mask_r  <= pwdata;
        REG_HEADER_TAG: header_tag_r <= pwdata;
        REG_DATA_TAG:   data_tag_r   <= pwdata;
        REG_END_TAG:    end_tag_r    <= pwdata;
        REG_FILLER_TAG: filler_tag_r <= pwdata;
        REG_SIXTEEN:    sixteen_r    <= pwdata[0];
        REG_SEL_MASK:   sel_mask_r   <= pwdata;
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_TYPE_MASK:  prdata = type_mask_r;
      REG_HEADER_TAG: prdata = header_tag_r;
      REG_DATA_TAG:   prdata = data_tag_r;
      REG_END_TAG:    prdata = end_tag_r;
      REG_FILLER_TAG: prdata = filler_tag_r;
      REG_SIXTEEN:    prdata = {31'b0, sixteen_r};
      REG_SEL_MASK:   prdata = sel_mask_r;
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg.type_mask  = type_mask_r;
  assign cfg.header_tag = header_tag_r;
  assign cfg.data_tag   = data_tag_r;
  assign cfg.end_tag    = end_tag_r;
  assign cfg.filler_tag = filler_tag_r;
  assign cfg.sixteen    = sixteen_r;
  assign cfg.sel_mask   = sel_mask_r;

  qdc_front #(.CHANNELS(CHANNELS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .mode          (in_mode),
    .word          (in_word),
    .query_channel (in_query_channel),
    .query_bin     (in_query_bin),
    .cfg           (cfg),
    .clr_busy      (clr_busy),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in),
    .cmd_full      (cmd_full)
  );

  qdc_fifo #(.T(cmd_t), .DEPTH(4)) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_dout),
    .empty (cmd_empty)
  );

  qdc_back #(.CHANNELS(CHANNELS), .BINS(BINS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .clr_busy  (clr_busy),
    .cmd_empty (cmd_empty),
    .cmd_dout  (cmd_dout),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  qdc_fifo #(.T(res_t), .DEPTH(4)) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign out_kind              = res_dout.kind;
  assign out_channel           = res_dout.channel;
  assign out_value             = res_dout.value;
  assign out_event_number      = res_dout.event_number;
  assign out_events_seen       = res_dout.events_seen;
  assign out_bin_count         = res_dout.bin_count;
  assign out_channel_hit_count = res_dout.hit_count;
  assign out_last              = res_dout.last;

endmodule

`default_nettype wire

### rtl/qdc_fifo.sv
// ----------------------------------------------------------------------------
// qdc_fifo
// Small register queue, used between front and back end and on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module qdc_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/qdc_front.sv
// ----------------------------------------------------------------------------
// qdc_front
// Accepts words, runs the header / data / end-of-block parser and queues
// commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module qdc_front #(
  parameter int CHANNELS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic          mode,
  input  logic [31:0]   word,
  input  logic [4:0]    query_channel,
  input  logic [11:0]   query_bin,
  input  qdc_pkg::cfg_t cfg,
  input  logic          clr_busy,
  output logic          cmd_push,
  output qdc_pkg::cmd_t cmd,
  input  logic          cmd_full
);
  import qdc_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [5:0]  exp_r, exp_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] total_r, total_nxt;
  logic        acc;
  logic [31:0] wtype;
  logic [5:0]  ch6;

  assign full  = cmd_full | clr_busy;
  assign acc   = push & ~full;
  assign wtype = word & cfg.type_mask;
  assign ch6   = cfg.sixteen ? word[22:17] : word[21:16];

  always_comb begin
    phase_nxt  = phase_r;
    exp_nxt    = exp_r;
    pos_nxt    = pos_r;
    total_nxt  = total_r;
    cmd_push   = 1'b0;
    cmd.op     = OP_ERR;
    cmd.ch     = '0;
    cmd.val    = '0;
    cmd.evn    = '0;
    cmd.events = total_r;
    if (acc) begin
      if (mode) begin
        cmd_push = 1'b1;
        cmd.op   = OP_QRY;
        cmd.ch   = {1'b0, query_channel};
        cmd.val  = query_bin;
      end else if (wtype == cfg.filler_tag) begin
        cmd_push = 1'b0;
      end else begin
        case (phase_r)
          PH_DATA: begin
            if (wtype != cfg.data_tag) begin
              phase_nxt = PH_HEADER;
              cmd_push  = 1'b1;
            end else begin
              // out-of-range channels still count toward the event length
              if (ch6 < 6'(CHANNELS)) begin
                cmd_push = 1'b1;
                cmd.op   = OP_DATA;
                cmd.ch   = ch6;
                cmd.val  = word[11:0];
              end
              if (pos_r == exp_r - 6'd1) begin
                phase_nxt = PH_EOB;
              end
              pos_nxt = pos_r + 6'd1;
            end
          end
          PH_EOB: begin
            phase_nxt = PH_HEADER;
            cmd_push  = 1'b1;
            if (wtype == cfg.end_tag) begin
              cmd.op  = OP_EOB;
              cmd.evn = word[23:0];
            end
          end
          default: begin
            phase_nxt = PH_HEADER;
            cmd_push  = 1'b1;
            if (wtype == cfg.header_tag) begin
              exp_nxt    = word[13:8];
              pos_nxt    = '0;
              total_nxt  = total_r + 32'd1;
              phase_nxt  = (word[13:8] != 6'd0) ? PH_DATA : PH_EOB;
              cmd.op     = OP_HDR;
              cmd.events = total_r + 32'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      exp_r   <= '0;
      pos_r   <= '0;
      total_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      exp_r   <= exp_nxt;
      pos_r   <= pos_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/qdc_back.sv
// ----------------------------------------------------------------------------
// qdc_back
// Executes queued commands: histogram and hit-count updates, channel value
// store, end-of-event channel scan and histogram reads.
// ----------------------------------------------------------------------------
`default_nettype none

module qdc_back #(
  parameter int CHANNELS = 32,
  parameter int BINS     = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  qdc_pkg::cfg_t cfg,
  output logic          clr_busy,
  input  logic          cmd_empty,
  input  qdc_pkg::cmd_t cmd_dout,
  output logic          cmd_pop,
  output logic          res_push,
  output qdc_pkg::res_t res,
  input  logic          res_full
);
  import qdc_pkg::*;

  localparam int HDEPTH = CHANNELS * BINS;
  localparam int HA_W   = $clog2(HDEPTH);
  localparam int CH_W   = $clog2(CHANNELS);
  localparam logic [32:0] CH_MASK = (33'd1 << CHANNELS) - 33'd1;

  logic [31:0] hist_mem [HDEPTH];
  logic [31:0] hits_mem [CHANNELS];
  logic [11:0] val_mem  [CHANNELS];

  bst_t              state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [4:0]        c_r, c_nxt;
  logic [HA_W-1:0]   clr_r, clr_nxt;
  logic [CHANNELS-1:0] valid_r;

  logic [31:0]       hist_rd_r, hits_rd_r;
  logic [11:0]       val_rd_r;

  logic [CH_W-1:0]   ch_idx, c_idx;
  logic              ch_ok, bin_ok;
  logic [HA_W-1:0]   hist_addr;
  logic [31:0]       sel_eff, sel_hi;
  logic              rd_en, scan_rd;
  logic              hist_we, hits_we, val_we, valid_clr;
  logic [HA_W-1:0]   hist_wa;
  logic [CH_W-1:0]   hits_wa;
  logic [31:0]       hist_wd, hits_wd;

  assign ch_idx    = cmd_r.ch[CH_W-1:0];
  assign c_idx     = c_r[CH_W-1:0];
  assign ch_ok     = cmd_r.ch < 6'(CHANNELS);
  assign bin_ok    = {1'b0, cmd_r.val} < 13'(BINS);
  assign hist_addr = HA_W'(ch_idx) * HA_W'(BINS) + HA_W'(cmd_r.val);
  assign sel_eff   = cfg.sel_mask & CH_MASK[31:0];
  assign sel_hi    = sel_eff & (32'hFFFF_FFFE << c_r);
  assign clr_busy  = (state_r == B_CLR);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    c_nxt     = c_r;
    clr_nxt   = clr_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    rd_en     = 1'b0;
    scan_rd   = 1'b0;
    hist_we   = 1'b0;
    hits_we   = 1'b0;
    val_we    = 1'b0;
    valid_clr = 1'b0;
    hist_wa   = hist_addr;
    hits_wa   = ch_idx;
    hist_wd   = hist_rd_r + 32'd1;
    hits_wd   = hits_rd_r + 32'd1;
    res              = '0;
    res.kind         = K_ERR;
    res.events_seen  = cmd_r.events;
    case (state_r)
      B_CLR: begin
        hist_we = 1'b1;
        hist_wa = clr_r;
        hist_wd = '0;
        hits_wa = clr_r[CH_W-1:0];
        hits_wd = '0;
        hits_we = (clr_r < HA_W'(CHANNELS));
        if (clr_r == HA_W'(HDEPTH - 1)) begin
          state_nxt = B_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      B_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_dout;
          if (cmd_dout.op == OP_DATA || cmd_dout.op == OP_QRY) begin
            state_nxt = B_RD;
          end else begin
            state_nxt = B_EMIT;
          end
        end
      end
      B_RD: begin
        rd_en     = ch_ok;
        state_nxt = B_MEM;
      end
      B_MEM: begin
        res.channel = cmd_r.ch[4:0];
        res.last    = 1'b1;
        if (cmd_r.op == OP_DATA) begin
          res.kind  = K_DATA;
          res.value = {4'b0, cmd_r.val};
        end else begin
          res.kind      = K_QRY;
          res.bin_count = (ch_ok && bin_ok) ? hist_rd_r : 32'd0;
          res.hit_count = ch_ok ? hits_rd_r : 32'd0;
        end
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = B_IDLE;
          if (cmd_r.op == OP_DATA) begin
            hist_we = bin_ok;
            hits_we = 1'b1;
            val_we  = 1'b1;
          end
        end
      end
      B_EMIT: begin
        res.last = 1'b1;
        case (cmd_r.op)
          OP_HDR: res.kind = K_HDR;
          OP_EOB: begin
            res.kind         = K_EOB;
            res.event_number = cmd_r.evn;
            res.last         = (sel_eff == 32'd0);
          end
          default: res.kind = K_ERR;
        endcase
        if (!res_full) begin
          res_push  = 1'b1;
          valid_clr = (cmd_r.op == OP_HDR);
          c_nxt     = '0;
          state_nxt = (cmd_r.op == OP_EOB && sel_eff != 32'd0) ? B_SCAN : B_IDLE;
        end
      end
      B_SCAN: begin
        if (sel_eff[c_r]) begin
          scan_rd   = 1'b1;
          state_nxt = B_SEL;
        end else begin
          c_nxt = c_r + 5'd1;
        end
      end
      B_SEL: begin
        res.kind    = K_SEL;
        res.channel = c_r;
        res.value   = valid_r[c_idx] ? {4'b0, val_rd_r} : VALUE_ABSENT;
        res.last    = (sel_hi == 32'd0);
        if (!res_full) begin
          res_push = 1'b1;
          if (sel_hi == 32'd0) begin
            state_nxt = B_IDLE;
          end else begin
            c_nxt     = c_r + 5'd1;
            state_nxt = B_SCAN;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLR;
      clr_r   <= '0;
      c_r     <= '0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      c_r     <= c_nxt;
      if (valid_clr) begin
        valid_r <= '0;
      end else if (val_we) begin
        valid_r[ch_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  // histogram: one write, one registered read
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (rd_en) begin
      hist_rd_r <= hist_mem[hist_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (hits_we) begin
      hits_mem[hits_wa] <= hits_wd;
    end
    if (rd_en) begin
      hits_rd_r <= hits_mem[ch_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[ch_idx] <= cmd_r.val;
    end
    if (scan_rd) begin
      val_rd_r <= val_mem[c_idx];
    end
  end

endmodule

`default_nettype wire

### rtl/qdc_chk.sv
// ----------------------------------------------------------------------------
// qdc_chk
// Port-level checks on the result stream of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module qdc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  out_kind,
  input logic [15:0] out_value,
  input logic [23:0] out_event_number,
  input logic [31:0] out_bin_count,
  input logic [31:0] out_channel_hit_count,
  input logic        out_last
);
  import qdc_pkg::*;

  // a waiting beat holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_kind) && $stable(out_last)))
    else $error("result beat changed while stalled");

  // header, error, data and histogram read beats end their item
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_kind == K_HDR || out_kind == K_ERR ||
                out_kind == K_DATA || out_kind == K_QRY)) |-> out_last)
    else $error("single-beat kind without last");

  // counts only on histogram reads
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != K_QRY) |->
      (out_bin_count == 32'd0 && out_channel_hit_count == 32'd0))
    else $error("counts on a non-read beat");

  // event number only on event end
  a_evn: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != K_EOB) |-> (out_event_number == 24'd0))
    else $error("event number on a non-end beat");

  // data values are 12-bit
  a_value: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == K_DATA) |-> (out_value[15:12] == 4'd0))
    else $error("data value wider than 12 bits");

endmodule

bind qdc_event_stream_parser qdc_chk u_qdc_chk (.*);

`default_nettype wire

### bench/qdc_event_stream_parser_checker.sv
// ----------------------------------------------------------------------------
// qdc_event_stream_parser_checker
// Watches the input, result and register ports of the stream parser, predicts
// the result beats of every accepted input beat and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module qdc_event_stream_parser_checker #(
  parameter int CHANNELS = 32,
  parameter int BINS     = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic        in_mode,
  input  logic [31:0] in_word,
  input  logic [4:0]  in_query_channel,
  input  logic [11:0] in_query_bin,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  out_kind,
  input  logic [4:0]  out_channel,
  input  logic [15:0] out_value,
  input  logic [23:0] out_event_number,
  input  logic [31:0] out_events_seen,
  input  logic [31:0] out_bin_count,
  input  logic [31:0] out_channel_hit_count,
  input  logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  import qdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t        cfg;
  phase_t      phase;
  logic [5:0]  n_expected;
  logic [5:0]  position;
  logic [15:0] ch_value [CHANNELS];
  logic [31:0] ev_total;
  logic [31:0] hist [int];
  logic [31:0] hits [CHANNELS];
  res_t        awaited [$];

  assign pending = awaited.size();

  function automatic res_t mk(kind_t k, logic [4:0] ch, logic [15:0] v, logic [23:0] evn,
                              logic [31:0] bc, logic [31:0] hc);
    res_t r;
    r.kind = k; r.channel = ch; r.value = v; r.event_number = evn;
    r.events_seen = ev_total; r.bin_count = bc; r.hit_count = hc; r.last = 1'b0;
    return r;
  endfunction

  task automatic parse_beat(logic mode, logic [31:0] w, logic [4:0] qch, logic [11:0] qbin);
    res_t        rs [$];
    logic [31:0] ty;
    logic [5:0]  ch;
    logic [11:0] v;
    logic [31:0] bc, hc;
    int          key;
    ty = w & cfg.type_mask;
    if (mode) begin
      bc = '0; hc = '0;
      if (qch < CHANNELS) begin
        hc = hits[qch];
        key = qch * BINS + qbin;
        if (qbin < BINS && hist.exists(key)) bc = hist[key];
      end
      rs.push_back(mk(K_QRY, qch, '0, '0, bc, hc));
    end else if (ty == cfg.filler_tag) begin
      return;
    end else if (phase == PH_DATA) begin
      if (ty != cfg.data_tag) begin
        phase = PH_HEADER;
        rs.push_back(mk(K_ERR, '0, '0, '0, '0, '0));
      end else begin
        ch = cfg.sixteen ? w[22:17] : w[21:16];
        v = w[11:0];
        if (ch < CHANNELS) begin
          key = ch * BINS + v;
          if (v < BINS) hist[key] = (hist.exists(key) ? hist[key] : 32'd0) + 32'd1;
          ch_value[ch] = {4'd0, v};
          hits[ch]++;
          rs.push_back(mk(K_DATA, ch[4:0], {4'd0, v}, '0, '0, '0));
        end
        if (position == 6'(n_expected - 1)) phase = PH_EOB;
        position++;
      end
    end else if (phase == PH_EOB) begin
      phase = PH_HEADER;
      if (ty != cfg.end_tag) begin
        rs.push_back(mk(K_ERR, '0, '0, '0, '0, '0));
      end else begin
        rs.push_back(mk(K_EOB, '0, '0, w[23:0], '0, '0));
        for (int c = 0; c < CHANNELS; c++)
          if (cfg.sel_mask[c]) rs.push_back(mk(K_SEL, 5'(c), ch_value[c], '0, '0, '0));
      end
    end else begin
      if (ty != cfg.header_tag) begin
        phase = PH_HEADER;
        rs.push_back(mk(K_ERR, '0, '0, '0, '0, '0));
      end else begin
        n_expected = w[13:8];
        position = '0;
        ev_total++;
        foreach (ch_value[i]) ch_value[i] = VALUE_ABSENT;
        phase = (n_expected != 6'd0) ? PH_DATA : PH_EOB;
        rs.push_back(mk(K_HDR, '0, '0, '0, '0, '0));
      end
    end
    // a data word for a channel out of range gives no beat at all
    if (rs.size() > 0) begin
      rs[rs.size()-1].last = 1'b1;
      foreach (rs[i]) awaited.push_back(rs[i]);
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      cfg = '0;
      cfg.type_mask = 32'h0700_0000; cfg.header_tag = 32'h0200_0000;
      cfg.end_tag = 32'h0400_0000;   cfg.filler_tag = 32'h0600_0000;
      phase = PH_HEADER; n_expected = '0; position = '0; ev_total = '0;
      foreach (ch_value[i]) ch_value[i] = VALUE_ABSENT;
      foreach (hits[i]) hits[i] = '0;
      hist.delete();
      awaited.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_TYPE_MASK:  cfg.type_mask  = pwdata;
          REG_HEADER_TAG: cfg.header_tag = pwdata;
          REG_DATA_TAG:   cfg.data_tag   = pwdata;
          REG_END_TAG:    cfg.end_tag    = pwdata;
          REG_FILLER_TAG: cfg.filler_tag = pwdata;
          REG_SIXTEEN:    cfg.sixteen    = pwdata[0];
          REG_SEL_MASK:   cfg.sel_mask   = pwdata;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (awaited.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat kind %0d", out_kind);
        end else begin
          e = awaited.pop_front();
          if (out_kind !== e.kind || out_channel !== e.channel || out_value !== e.value ||
              out_event_number !== e.event_number || out_events_seen !== e.events_seen ||
              out_bin_count !== e.bin_count || out_channel_hit_count !== e.hit_count ||
              out_last !== e.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: exp k%0d ch%0d v%h ev%h seen%0d bc%0d hc%0d l%0d",
                e.kind, e.channel, e.value, e.event_number, e.events_seen, e.bin_count,
                e.hit_count, e.last);
              $display("          got k%0d ch%0d v%h ev%h seen%0d bc%0d hc%0d l%0d",
                out_kind, out_channel, out_value, out_event_number,
                out_events_seen, out_bin_count, out_channel_hit_count, out_last);
            end
          end
        end
      end
      if (push && !full) parse_beat(in_mode, in_word, in_query_channel, in_query_bin);
    end
  end

endmodule

`default_nettype wire

### bench/qdc_event_stream_parser_test.sv
// ----------------------------------------------------------------------------
// qdc_event_stream_parser_test
// Drives register settings, directed and random readout streams and histogram
// reads into the parser, with random gaps and a long result back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module qdc_event_stream_parser_test;
  import qdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 1_500_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_mode = 1'b0;
  logic [31:0] in_word = '0;
  logic [4:0]  in_query_channel = '0;
  logic [11:0] in_query_bin = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_kind;
  logic [4:0]  out_channel;
  logic [15:0] out_value;
  logic [23:0] out_event_number;
  logic [31:0] out_events_seen, out_bin_count, out_channel_hit_count;
  logic        out_last;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic        pready;
  int          fail_count, pending;
  longint      cycles = 0;
  bit          hold_results = 1'b0;

  // per-phase register shadow for building well-formed words
  logic [31:0] t_mask, t_hdr, t_data, t_end, t_fill;
  logic        t_sixteen;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  qdc_event_stream_parser dut (.*);

  qdc_event_stream_parser_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, or a long hold when asked
  initial begin
    int gap;
    forever begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0 || hold_results) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_results) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TYPE_MASK:  t_mask = v;
      REG_HEADER_TAG: t_hdr = v;
      REG_DATA_TAG:   t_data = v;
      REG_END_TAG:    t_end = v;
      REG_FILLER_TAG: t_fill = v;
      REG_SIXTEEN:    t_sixteen = v[0];
      default: ;
    endcase
  endtask

  task automatic send(logic mode, logic [31:0] w, logic [4:0] qc, logic [11:0] qb,
                      bit no_gap = 0);
    int gap;
    gap = 0;
    if (!no_gap && $urandom_range(0, 2) != 0) gap = $urandom_range(0, 12);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1; in_mode <= mode; in_word <= w;
    in_query_channel <= qc; in_query_bin <= qb;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic logic [31:0] tagged_word(logic [31:0] tag, logic [31:0] body);
    return (body & ~t_mask) | (tag & t_mask);
  endfunction

  function automatic logic [31:0] data_word(int ch, logic [11:0] v);
    logic [31:0] b;
    b = $urandom();
    b[11:0] = v;
    if (t_sixteen) b[22:17] = 6'(ch); else b[21:16] = 6'(ch);
    return tagged_word(t_data, b);
  endfunction

  task automatic send_event(int n, bit no_gap = 0);
    logic [31:0] b;
    b = $urandom(); b[13:8] = 6'(n);
    send(0, tagged_word(t_hdr, b), 0, 0, no_gap);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) send(0, tagged_word(t_fill, $urandom()), 0, 0, no_gap);
      send(0, data_word($urandom_range(0, 35), 12'($urandom_range(0, 15) == 0 ?
           $urandom() : $urandom_range(0, 7))), 0, 0, no_gap);
    end
    send(0, tagged_word(t_end, $urandom()), 0, 0, no_gap);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    t_mask = 32'h0700_0000; t_hdr = 32'h0200_0000; t_data = 0;
    t_end = 32'h0400_0000; t_fill = 32'h0600_0000; t_sixteen = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);

    // defaults, no selection: directed corner words
    send(0, 32'h0000_0000, 0, 0);
    send(0, 32'hFFFF_FFFF, 0, 0);
    send(0, 32'h0600_0000, 0, 0);
    send(0, 32'h0200_0000, 0, 0);
    send(0, 32'h0400_00AB, 0, 0);
    send(0, 32'h0200_3F00, 0, 0);
    send(0, 32'h001F_0FFF, 0, 0);
    send(0, 32'h0020_0005, 0, 0);
    send(0, 32'h0400_0000, 0, 0);
    send(1, 0, 5'd31, 12'hFFF);
    send(1, 0, 5'd0, 12'h000);
    drain();

    reg_write(REG_SEL_MASK, 32'hFFFF_FFFF);
    reg_write(REG_SIXTEEN, 32'h1);
    send_event(2);
    send(0, 32'h0200_0100, 0, 0);
    send(0, tagged_word(t_end, 0), 0, 0);
    send(1, 0, 5'd31, 12'd7);
    send(1, $urandom(), 5'd0, 12'd0);
    drain();

    // long result hold so the block fills and stalls
    reg_write(REG_SIXTEEN, 32'h0);
    hold_results = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_results = 1'b0;
      end
      begin
        for (int i = 0; i < 3; i++) send_event($urandom_range(0, 6), 1);
      end
    join
    drain();

    for (int phase_i = 0; phase_i < 3; phase_i++) begin
      case (phase_i)
        0: begin
          reg_write(REG_TYPE_MASK, 32'hF000_0000);
          reg_write(REG_HEADER_TAG, 32'hA000_0000);
          reg_write(REG_DATA_TAG, 32'h3000_0000);
          reg_write(REG_END_TAG, 32'hC000_0000);
          reg_write(REG_FILLER_TAG, 32'hF000_0000);
          reg_write(REG_SEL_MASK, $urandom());
        end
        1: begin
          reg_write(REG_TYPE_MASK, 32'h0000_0000);
          reg_write(REG_FILLER_TAG, 32'hFFFF_FFFF);
          reg_write(REG_SEL_MASK, 32'h8000_0001);
          reg_write(REG_SIXTEEN, 32'h1);
        end
        default: begin
          reg_write(REG_TYPE_MASK, 32'h0700_0000);
          reg_write(REG_HEADER_TAG, 32'h0200_0000);
          reg_write(REG_DATA_TAG, 32'h0);
          reg_write(REG_END_TAG, 32'h0400_0000);
          reg_write(REG_FILLER_TAG, 32'h0600_0000);
          reg_write(REG_SEL_MASK, 32'h0000_0000);
          reg_write(REG_SIXTEEN, 32'h0);
        end
      endcase
      for (int k = 0; k < 8; k++) begin
        case ($urandom_range(0, 9))
          0: send(0, $urandom(), 0, 0);
          1: send(1, $urandom(), 5'($urandom()), 12'($urandom_range(0, 7)));
          2: begin
            send(0, tagged_word(t_hdr, 32'h0000_0300), 0, 0);
            send(0, tagged_word(t_end, $urandom()), 0, 0);
          end
          default: send_event($urandom_range(0, 5));
        endcase
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
